### rtl/skp_pkg.sv
// Shared types, codes and sizes for the skyline rectangle packer.
package skp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DIM_W = 13;
  localparam int COORD_W = 12;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 2'd1;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PLACED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOROOM = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOOBIG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic             command;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]  place_x;
    logic [COORD_W-1:0]  place_y;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } pt_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

### rtl/skp_mem.sv
// Skyline point memory: one write port, one registered read port.
module skp_mem #(
  parameter int Depth = skp_pkg::MAX_POINTS_DEF,
  parameter int AddrW = $clog2(skp_pkg::MAX_POINTS_DEF)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output skp_pkg::pt_t     rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  skp_pkg::pt_t     wr_data
);

  skp_pkg::pt_t mem_r [Depth];
  skp_pkg::pt_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/skp_engine.sv
// Placement sequencer: scans the skyline memory, picks the spot, rewrites points.
module skp_engine #(
  parameter int MaxPoints = skp_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [skp_pkg::DIM_W-1:0] bin_w,
  input  logic [skp_pkg::DIM_W-1:0] bin_h,
  input  logic                     new_bin,
  input  logic                     start,
  output logic                     ready,
  input  skp_pkg::in_t             cmd,
  output skp_pkg::res_t            res,
  input  logic                     res_ready
);

  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int DW = skp_pkg::DIM_W;
  localparam int WW = 2 * DW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT0  = 5'd1;
  localparam logic [4:0] S_INIT1  = 5'd2;
  localparam logic [4:0] S_A_RD0  = 5'd3;
  localparam logic [4:0] S_A_US0  = 5'd4;
  localparam logic [4:0] S_A_RD   = 5'd5;
  localparam logic [4:0] S_A_US   = 5'd6;
  localparam logic [4:0] S_LEG    = 5'd7;
  localparam logic [4:0] S_B_RD   = 5'd8;
  localparam logic [4:0] S_B_US   = 5'd9;
  localparam logic [4:0] S_CMP0   = 5'd10;
  localparam logic [4:0] S_CMP1   = 5'd11;
  localparam logic [4:0] S_NEXT   = 5'd12;
  localparam logic [4:0] S_FIN    = 5'd13;
  localparam logic [4:0] S_F_US   = 5'd14;
  localparam logic [4:0] S_F3_US  = 5'd15;
  localparam logic [4:0] S_DRP_RD = 5'd16;
  localparam logic [4:0] S_DRP_WR = 5'd17;
  localparam logic [4:0] S_INS_RD = 5'd18;
  localparam logic [4:0] S_INS_WR = 5'd19;
  localparam logic [4:0] S_TOP    = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  logic [4:0]    state_r, state_nxt;
  logic          init_pend_r, init_pend_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [CW-1:0] dst_r, dst_nxt;
  logic [DW-1:0] rw_r, rw_nxt;
  logic [DW-1:0] rh_r, rh_nxt;
  logic [DW-1:0] xi_r, xi_nxt;
  logic [DW-1:0] yi_r, yi_nxt;
  logic [DW:0]   right_r, right_nxt;
  logic [DW-1:0] top_r, top_nxt;
  logic [DW-1:0] px_r, px_nxt;
  logic [DW-1:0] py_r, py_nxt;
  logic [WW-1:0] prod_r, prod_nxt;
  logic          prod_vld_r, prod_vld_nxt;
  logic [WW-1:0] waste_r, waste_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] bi_r, bi_nxt;
  logic [CW-1:0] bj_r, bj_nxt;
  logic [DW-1:0] bx_r, bx_nxt;
  logic [DW-1:0] by_r, by_nxt;
  logic [DW-1:0] btop_r, btop_nxt;
  logic [WW-1:0] bwaste_r, bwaste_nxt;
  skp_pkg::out_t res_r, res_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  skp_pkg::pt_t  rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  skp_pkg::pt_t  wr_data;
  logic [DW-1:0] seg_end;
  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  logic          too_big;

  skp_mem #(
    .Depth (MaxPoints),
    .AddrW (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign ready = (state_r == S_IDLE) && !init_pend_r;
  assign res.valid = (state_r == S_DONE);
  assign res.data = res_r;

  assign too_big = (cmd.rect_width == '0) || (cmd.rect_height == '0) ||
                   (cmd.rect_width > bin_w) || (cmd.rect_height > bin_h);

  // clipped segment width and height gap for the waste term
  assign seg_end = ({1'b0, rd_data.x} < right_r) ? rd_data.x : right_r[DW-1:0];
  assign dx = seg_end - px_r;
  assign dy = top_r - py_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    init_pend_nxt = init_pend_r | new_bin;
    clr_pend_nxt = clr_pend_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    k_nxt = k_r;
    j_nxt = j_r;
    src_nxt = src_r;
    dst_nxt = dst_r;
    rw_nxt = rw_r;
    rh_nxt = rh_r;
    xi_nxt = xi_r;
    yi_nxt = yi_r;
    right_nxt = right_r;
    top_nxt = top_r;
    px_nxt = px_r;
    py_nxt = py_r;
    prod_nxt = prod_r;
    prod_vld_nxt = 1'b0;
    waste_nxt = prod_vld_r ? waste_r + prod_r : waste_r;
    found_nxt = found_r;
    bi_nxt = bi_r;
    bj_nxt = bj_r;
    bx_nxt = bx_r;
    by_nxt = by_r;
    btop_nxt = btop_r;
    bwaste_nxt = bwaste_r;
    res_nxt = res_r;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_r)
      S_IDLE: begin
        if (init_pend_r) begin
          state_nxt = S_INIT0;
        end else if (start) begin
          rw_nxt = cmd.rect_width;
          rh_nxt = cmd.rect_height;
          res_nxt = '0;
          if (cmd.command == skp_pkg::CMD_CLEAR) begin
            clr_pend_nxt = 1'b1;
            state_nxt = S_INIT0;
          end else if (too_big) begin
            res_nxt.status = skp_pkg::ST_TOOBIG;
            state_nxt = S_DONE;
          end else begin
            i_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = S_A_RD0;
          end
        end
      end
      S_INIT0: begin
        wr_en = 1'b1;
        wr_addr = '0;
        wr_data = '0;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        wr_en = 1'b1;
        wr_addr = AW'(1);
        wr_data.x = bin_w;
        wr_data.y = '0;
        cnt_nxt = CW'(2);
        init_pend_nxt = new_bin;
        if (clr_pend_r) begin
          clr_pend_nxt = 1'b0;
          res_nxt = '0;
          res_nxt.status = skp_pkg::ST_CLEARED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // first pass: find the span end and the tallest segment
      S_A_RD0: begin
        if (i_r + CW'(1) >= cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_en = 1'b1;
          rd_addr = i_r[AW-1:0];
          state_nxt = S_A_US0;
        end
      end
      S_A_US0: begin
        xi_nxt = rd_data.x;
        yi_nxt = rd_data.y;
        top_nxt = rd_data.y;
        right_nxt = {1'b0, rd_data.x} + {1'b0, rw_r};
        k_nxt = i_r + CW'(1);
        state_nxt = S_A_RD;
      end
      S_A_RD: begin
        if (k_r >= cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_en = 1'b1;
          rd_addr = k_r[AW-1:0];
          state_nxt = S_A_US;
        end
      end
      S_A_US: begin
        if ({1'b0, rd_data.x} >= right_r) begin
          j_nxt = k_r;
          state_nxt = S_LEG;
        end else begin
          if (rd_data.y > top_r) begin
            top_nxt = rd_data.y;
          end
          k_nxt = k_r + CW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_LEG: begin
        if (({1'b0, top_r} + {1'b0, rh_r}) >= {1'b0, bin_h}) begin
          state_nxt = S_NEXT;
        end else begin
          waste_nxt = '0;
          k_nxt = i_r + CW'(1);
          px_nxt = xi_r;
          py_nxt = yi_r;
          state_nxt = S_B_RD;
        end
      end
      // second pass: accumulate the waste under the rectangle
      S_B_RD: begin
        rd_en = 1'b1;
        rd_addr = k_r[AW-1:0];
        state_nxt = S_B_US;
      end
      S_B_US: begin
        prod_nxt = {{DW{1'b0}}, dx} * {{DW{1'b0}}, dy};
        prod_vld_nxt = 1'b1;
        px_nxt = rd_data.x;
        py_nxt = rd_data.y;
        if (k_r == j_r) begin
          state_nxt = S_CMP0;
        end else begin
          k_nxt = k_r + CW'(1);
          state_nxt = S_B_RD;
        end
      end
      S_CMP0: begin
        state_nxt = S_CMP1;
      end
      S_CMP1: begin
        if (!found_r || (waste_r < bwaste_r)) begin
          found_nxt = 1'b1;
          bi_nxt = i_r;
          bj_nxt = j_r;
          bx_nxt = xi_r;
          by_nxt = yi_r;
          btop_nxt = top_r;
          bwaste_nxt = waste_r;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        i_nxt = i_r + CW'(1);
        state_nxt = S_A_RD0;
      end
      // rewrite the skyline around the chosen spot
      S_FIN: begin
        if (!found_r) begin
          res_nxt.status = skp_pkg::ST_NOROOM;
          state_nxt = S_DONE;
        end else begin
          rd_en = 1'b1;
          rd_addr = bj_r[AW-1:0];
          right_nxt = {1'b0, bx_r} + {1'b0, rw_r};
          state_nxt = S_F_US;
        end
      end
      S_F_US: begin
        if ({1'b0, rd_data.x} == right_r) begin
          dst_nxt = bi_r + CW'(1);
          src_nxt = bj_r;
          state_nxt = S_DRP_RD;
        end else if (bj_r == bi_r + CW'(1)) begin
          if (cnt_r >= CW'(MaxPoints)) begin
            res_nxt.status = skp_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            dst_nxt = cnt_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(bj_r - CW'(1));
          state_nxt = S_F3_US;
        end
      end
      S_F3_US: begin
        wr_en = 1'b1;
        wr_addr = AW'(bj_r - CW'(1));
        wr_data.x = right_r[DW-1:0];
        wr_data.y = rd_data.y;
        dst_nxt = bi_r + CW'(1);
        src_nxt = bj_r - CW'(1);
        state_nxt = S_DRP_RD;
      end
      S_DRP_RD: begin
        if (src_r >= cnt_r) begin
          cnt_nxt = dst_r;
          state_nxt = S_TOP;
        end else begin
          rd_en = 1'b1;
          rd_addr = src_r[AW-1:0];
          state_nxt = S_DRP_WR;
        end
      end
      S_DRP_WR: begin
        wr_en = 1'b1;
        wr_addr = dst_r[AW-1:0];
        wr_data = rd_data;
        src_nxt = src_r + CW'(1);
        dst_nxt = dst_r + CW'(1);
        state_nxt = S_DRP_RD;
      end
      S_INS_RD: begin
        if (dst_r == bj_r) begin
          wr_en = 1'b1;
          wr_addr = bj_r[AW-1:0];
          wr_data.x = right_r[DW-1:0];
          wr_data.y = by_r;
          cnt_nxt = cnt_r + CW'(1);
          state_nxt = S_TOP;
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(dst_r - CW'(1));
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = dst_r[AW-1:0];
        wr_data = rd_data;
        dst_nxt = dst_r - CW'(1);
        state_nxt = S_INS_RD;
      end
      S_TOP: begin
        wr_en = 1'b1;
        wr_addr = bi_r[AW-1:0];
        wr_data.x = bx_r;
        wr_data.y = btop_r + rh_r;
        res_nxt.place_x = bx_r[skp_pkg::COORD_W-1:0];
        res_nxt.place_y = btop_r[skp_pkg::COORD_W-1:0];
        res_nxt.status = skp_pkg::ST_PLACED;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_pend_r <= 1'b1;
      clr_pend_r <= 1'b0;
      cnt_r <= CW'(2);
      prod_vld_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_pend_r <= init_pend_nxt;
      clr_pend_r <= clr_pend_nxt;
      cnt_r <= cnt_nxt;
      prod_vld_r <= prod_vld_nxt;
      found_r <= found_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    rw_r <= rw_nxt;
    rh_r <= rh_nxt;
    xi_r <= xi_nxt;
    yi_r <= yi_nxt;
    right_r <= right_nxt;
    top_r <= top_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    prod_r <= prod_nxt;
    waste_r <= waste_nxt;
    bi_r <= bi_nxt;
    bj_r <= bj_nxt;
    bx_r <= bx_nxt;
    by_r <= by_nxt;
    btop_r <= btop_nxt;
    bwaste_r <= bwaste_nxt;
    res_r <= res_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CW'(2)) && (cnt_r <= CW'(MaxPoints)))
    else $error("point count out of range");

  a_top_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOP) |-> found_r)
    else $error("skyline rewrite without a chosen spot");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_RD) |-> (cnt_r < CW'(MaxPoints)))
    else $error("point insert with a full table");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

endmodule

### rtl/skyline_rect_packer.sv
// Top level of the skyline rectangle packer: ports, config registers, result register.
//
// Usage: items enter on in_valid/in_ready with in_data (command, rect_width,
// rect_height). Each item yields exactly one result item on out_valid/out_ready
// with out_data (place_x, place_y, status). Items are worked one at a time, and
// the engine returns to idle after each result before it takes the next.
// A rejected rectangle goes straight to its result and a clear writes the empty
// skyline. A placement scans each start point: it reads the points under the
// rectangle to find their top and, where the spot is low enough, reads them again
// to sum the waste; then it rewrites the skyline, moving points through the
// single read port of the point memory. No room is reported once the scan ends.
// The result sits in an output register, so the next item is taken while a
// finished result waits; a stalled receiver holds the engine once a second
// result is ready. Reset sets both bin sizes to 256 and writes the empty
// skyline; in_ready and cfg_ready stay low while it is written. A write on
// cfg_valid/cfg_ready (index 0 width, 1 height, clamped to 4096) starts a new
// empty bin the same way and takes priority over a waiting input item; other
// indexes are ignored.
module skyline_rect_packer #(
  parameter int MaxPoints = skp_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  skp_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output skp_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [skp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skp_pkg::DIM_W-1:0]     cfg_data
);

  logic [skp_pkg::DIM_W-1:0] bin_w_r, bin_w_nxt;
  logic [skp_pkg::DIM_W-1:0] bin_h_r, bin_h_nxt;
  logic [skp_pkg::DIM_W-1:0] cfg_val;
  logic                      cfg_wr;
  logic                      new_bin;
  logic                      eng_ready;
  skp_pkg::res_t             res;
  logic                      res_ready;
  logic                      out_valid_r, out_valid_nxt;
  skp_pkg::out_t             out_data_r, out_data_nxt;

  skp_engine #(
    .MaxPoints (MaxPoints)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .bin_w     (bin_w_r),
    .bin_h     (bin_h_r),
    .new_bin   (new_bin),
    .start     (in_ready && in_valid),
    .ready     (eng_ready),
    .cmd       (in_data),
    .res       (res),
    .res_ready (res_ready)
  );

  // hold input items while a config write is offered
  assign in_ready = eng_ready && !cfg_valid;
  assign cfg_ready = eng_ready;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign cfg_val = (cfg_data > skp_pkg::DIM_MAX) ? skp_pkg::DIM_MAX : cfg_data;
  assign new_bin = cfg_wr && ((cfg_index == skp_pkg::CFG_BIN_WIDTH) ||
                              (cfg_index == skp_pkg::CFG_BIN_HEIGHT));

  // update bin sizes
  always_comb begin
    bin_w_nxt = bin_w_r;
    bin_h_nxt = bin_h_r;
    if (cfg_wr && (cfg_index == skp_pkg::CFG_BIN_WIDTH)) begin
      bin_w_nxt = cfg_val;
    end
    if (cfg_wr && (cfg_index == skp_pkg::CFG_BIN_HEIGHT)) begin
      bin_h_nxt = cfg_val;
    end
  end

  // hold the result item until taken
  assign res_ready = !out_valid_r || out_ready;
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_w_r <= skp_pkg::DIM_RESET;
      bin_h_r <= skp_pkg::DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      bin_w_r <= bin_w_nxt;
      bin_h_r <= bin_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

### dv/tb.sv
// Self-checking testbench for the skyline rectangle packer.
`timescale 1ns / 1ps

module tb;

  localparam int NPTS = skp_pkg::MAX_POINTS_DEF;
  localparam int DW = skp_pkg::DIM_W;
  localparam int XW = skp_pkg::COORD_W;
  localparam int IW = skp_pkg::CFG_IDX_W;

  typedef struct {
    skp_pkg::in_t  item;
    bit            typed;
    skp_pkg::out_t want;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  skp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  skp_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  // Predictor copy of the skyline and bin size
  int sky_x [NPTS];
  int sky_y [NPTS];
  int sky_cnt;
  int bin_w;
  int bin_h;

  skp_pkg::out_t pending_results [$];
  int            errors;
  bit            steady_in;
  bit            steady_out;
  int            n_items;
  int            n_results;
  int            n_status [8];
  dir_row_t      dir_rows [12];

  skyline_rect_packer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Start an empty bin
  function automatic void sky_clear();
    for (int k = 0; k < NPTS; k++) begin
      sky_x[k] = 0;
      sky_y[k] = 0;
    end
    sky_x[1] = bin_w;
    sky_cnt = 2;
  endfunction

  // Remove points first..last-1
  function automatic void sky_drop(int first, int last);
    int n;
    n = last - first;
    if (n == 0) return;
    for (int k = first; k + n < sky_cnt; k++) begin
      sky_x[k] = sky_x[k + n];
      sky_y[k] = sky_y[k + n];
    end
    sky_cnt -= n;
  endfunction

  // Find the least-waste spot and rewrite the skyline
  function automatic skp_pkg::out_t pack_predict(skp_pkg::in_t it);
    skp_pkg::out_t r;
    int     w;
    int     h;
    int     j;
    int     top;
    int     right;
    int     seg_r;
    int     best_i;
    int     best_j;
    int     best_top;
    longint waste;
    longint best_waste;
    bit     found;
    r = '0;
    w = int'(it.rect_width);
    h = int'(it.rect_height);
    if (it.command == skp_pkg::CMD_CLEAR) begin
      sky_clear();
      r.status = skp_pkg::ST_CLEARED;
      return r;
    end
    if (w == 0 || h == 0 || w > bin_w || h > bin_h) begin
      r.status = skp_pkg::ST_TOOBIG;
      return r;
    end
    found = 0;
    j = 0;
    best_i = 0;
    best_j = 0;
    best_top = 0;
    best_waste = 0;
    for (int i = 0; i + 1 < sky_cnt; i++) begin
      top = 0;
      waste = 0;
      if (j < i + 1) j = i + 1;
      while (j < sky_cnt && sky_x[j] < sky_x[i] + w) j++;
      if (j >= sky_cnt) break;
      for (int k = i; k < j; k++)
        if (sky_y[k] > top) top = sky_y[k];
      if (top + h >= bin_h) continue;
      right = sky_x[i] + w;
      for (int k = i; k < j; k++) begin
        seg_r = sky_x[k + 1] < right ? sky_x[k + 1] : right;
        waste += longint'(seg_r - sky_x[k]) * longint'(top - sky_y[k]);
      end
      if (!found || waste < best_waste) begin
        found = 1;
        best_i = i;
        best_j = j;
        best_top = top;
        best_waste = waste;
      end
    end
    if (!found) begin
      r.status = skp_pkg::ST_NOROOM;
      return r;
    end
    right = sky_x[best_i] + w;
    if (sky_x[best_j] == right) begin
      sky_drop(best_i + 1, best_j);
    end else if (best_j == best_i + 1) begin
      if (sky_cnt >= NPTS) begin
        r.status = skp_pkg::ST_FULL;
        return r;
      end
      for (int k = sky_cnt; k > best_j; k--) begin
        sky_x[k] = sky_x[k - 1];
        sky_y[k] = sky_y[k - 1];
      end
      sky_x[best_j] = right;
      sky_y[best_j] = sky_y[best_i];
      sky_cnt++;
    end else begin
      sky_x[best_j - 1] = right;
      sky_drop(best_i + 1, best_j - 1);
    end
    sky_y[best_i] = best_top + h;
    r.place_x = sky_x[best_i][XW-1:0];
    r.place_y = best_top[XW-1:0];
    r.status = skp_pkg::ST_PLACED;
    return r;
  endfunction

  // Send one item, idling first at random; record its expected result
  task automatic send_item(skp_pkg::in_t it, bit typed, skp_pkg::out_t want);
    skp_pkg::out_t got;
    if (!steady_in && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    got = pack_predict(it);
    pending_results.push_back(typed ? want : got);
    n_items++;
  endtask

  // Hold the input until every result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    int v;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    v = int'(val) > 4096 ? 4096 : int'(val);
    if (idx == skp_pkg::CFG_BIN_WIDTH) begin
      bin_w = v;
      sky_clear();
    end else if (idx == skp_pkg::CFG_BIN_HEIGHT) begin
      bin_h = v;
      sky_clear();
    end
  endtask

  function automatic logic [DW-1:0] pick_dim(int lim);
    int p;
    int m;
    p = $urandom_range(99);
    m = lim < 1 ? 1 : lim;
    if (p < 80) return DW'($urandom_range(1, (m / 4 < 1) ? 1 : m / 4));
    if (p < 90) return DW'($urandom_range(1, m));
    if (p < 95) return DW'(lim);
    return DW'($urandom_range(0, 8191));
  endfunction

  task automatic send_random(int count);
    skp_pkg::in_t it;
    for (int n = 0; n < count; n++) begin
      it.command     = ($urandom_range(99) < 4) ? skp_pkg::CMD_CLEAR : skp_pkg::CMD_PLACE;
      it.rect_width  = pick_dim(bin_w);
      it.rect_height = pick_dim(bin_h);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Narrow columns in a shallow bin, to run the point table out
  task automatic send_columns(int count);
    skp_pkg::in_t it;
    for (int n = 0; n < count; n++) begin
      it.command     = ($urandom_range(99) < 2) ? skp_pkg::CMD_CLEAR : skp_pkg::CMD_PLACE;
      it.rect_width  = ($urandom_range(99) < 90) ? 13'd1 : 13'd2;
      it.rect_height = ($urandom_range(99) < 80) ? 13'd1 : 13'd2;
      send_item(it, 1'b0, '0);
    end
  endtask

  // Take result items and check them against the oldest expectation
  always @(posedge clk) begin
    skp_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_out ? 1'b1 : ($urandom_range(99) >= 33);
      if (out_valid && out_ready) begin
        n_results++;
        n_status[out_data.status]++;
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: x=%0d y=%0d status=%0d",
                 out_data.place_x, out_data.place_y, out_data.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.place_x !== want.place_x) begin
            $error("place_x: expected %0d, got %0d", want.place_x, out_data.place_x);
            errors++;
          end
          if (out_data.place_y !== want.place_y) begin
            $error("place_y: expected %0d, got %0d", want.place_y, out_data.place_y);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    errors     = 0;
    n_items    = 0;
    n_results  = 0;
    steady_in  = 0;
    steady_out = 0;
    for (int k = 0; k < 8; k++) n_status[k] = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    bin_w = 256;
    bin_h = 256;
    sky_clear();

    // Directed rows at the reset bin of 256 x 256
    dir_rows = '{
      '{'{skp_pkg::CMD_PLACE, 13'd0, 13'd5}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_TOOBIG}},
      '{'{skp_pkg::CMD_PLACE, 13'd5, 13'd0}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_TOOBIG}},
      '{'{skp_pkg::CMD_PLACE, 13'd257, 13'd1}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_TOOBIG}},
      '{'{skp_pkg::CMD_PLACE, 13'd1, 13'd257}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_TOOBIG}},
      '{'{skp_pkg::CMD_PLACE, 13'd8191, 13'd8191}, 1'b1,
        '{12'd0, 12'd0, skp_pkg::ST_TOOBIG}},
      '{'{skp_pkg::CMD_PLACE, 13'd1, 13'd256}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_NOROOM}},
      '{'{skp_pkg::CMD_PLACE, 13'd256, 13'd255}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_PLACED}},
      '{'{skp_pkg::CMD_PLACE, 13'd1, 13'd1}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_NOROOM}},
      '{'{skp_pkg::CMD_CLEAR, 13'd8191, 13'd8191}, 1'b1,
        '{12'd0, 12'd0, skp_pkg::ST_CLEARED}},
      '{'{skp_pkg::CMD_PLACE, 13'd10, 13'd20}, 1'b1, '{12'd0, 12'd0, skp_pkg::ST_PLACED}},
      '{'{skp_pkg::CMD_PLACE, 13'd10, 13'd20}, 1'b0, '0},
      '{'{skp_pkg::CMD_PLACE, 13'd200, 13'd7}, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    send_random(40);
    // Let the block run dry once in the middle of traffic
    drain();
    send_random(40);

    // Largest bin, height written above range, no idling on either side
    write_reg(skp_pkg::CFG_BIN_WIDTH, 13'd4096);
    write_reg(skp_pkg::CFG_BIN_HEIGHT, 13'd8191);
    steady_in  = 1;
    steady_out = 1;
    send_random(50);
    steady_in  = 0;
    steady_out = 0;

    // Unused indexes leave the bin alone
    write_reg(2'd2, 13'd17);
    write_reg(2'd3, 13'd8191);
    send_random(10);

    // Smallest bin, then a zero width bin
    write_reg(skp_pkg::CFG_BIN_WIDTH, 13'd1);
    write_reg(skp_pkg::CFG_BIN_HEIGHT, 13'd1);
    send_random(10);
    write_reg(skp_pkg::CFG_BIN_HEIGHT, 13'd50);
    write_reg(skp_pkg::CFG_BIN_WIDTH, 13'd0);
    send_random(10);

    // Shallow wide bin: fill it column by column until the table is full
    write_reg(skp_pkg::CFG_BIN_WIDTH, 13'd100);
    write_reg(skp_pkg::CFG_BIN_HEIGHT, 13'd3);
    send_columns(160);

    write_reg(skp_pkg::CFG_BIN_WIDTH, 13'd256);
    write_reg(skp_pkg::CFG_BIN_HEIGHT, 13'd256);
    send_random(80);

    drain();
    repeat (50) @(posedge clk);
    $display("tb: %0d items, %0d results over several bin sizes", n_items, n_results);
    $display("tb: placed %0d, no room %0d, too big %0d, table full %0d, cleared %0d",
             n_status[skp_pkg::ST_PLACED], n_status[skp_pkg::ST_NOROOM],
             n_status[skp_pkg::ST_TOOBIG], n_status[skp_pkg::ST_FULL],
             n_status[skp_pkg::ST_CLEARED]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/skp_pkg.sv
rtl/skp_mem.sv
rtl/skp_engine.sv
rtl/skyline_rect_packer.sv
dv/tb.sv
